@@ hdl/opr_pkg.sv @@
// Package for the optimal page replacement unit: field widths, request and
// result structs, and the command/status structs between controller and datapath.
// No dependencies.
package opr_pkg;

  localparam int PAGE_W          = 16;
  localparam int IDX_W           = 6;
  localparam int SLOT_W          = 3;
  localparam int FAULT_W         = 7;
  localparam int FCOUNT_W        = 4;
  localparam int NF_W            = FCOUNT_W + 1;
  localparam int REF_DEPTH_DEF   = 64;
  localparam int FRAME_SLOTS_DEF = 8;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(3);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   ref_index;
    logic [PAGE_W-1:0]  ref_page;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
    logic               final_res;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted request's page
    logic rd_cur;     // read the reference at the simulation position
    logic cmp_take;   // resolve a hit or a fill into a free frame and emit
    logic scan_init;  // latch the current page and set up the look-ahead scan
    logic scan_step;  // one look-ahead scan step
    logic evict;      // replace the victim frame and emit
  } opr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic free_avail;
    logic scan_done;
    logic final_ref;
  } opr_stat_t;

endpackage

@@ hdl/opr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module opr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/opr_ctrl.sv @@
// Controller state machine of the optimal page replacement unit.
// Depends on opr_pkg for the command and status structs.
module opr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_last,
  input  opr_pkg::opr_stat_t stat_i,
  output opr_pkg::opr_cmd_t  cmd_o,
  output logic               busy
);

  import opr_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EVICT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (in_last) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.rd_cur = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.hit || stat_i.free_avail) begin
          cmd_o.cmp_take = 1'b1;
          state_nxt      = stat_i.final_ref ? ST_LOAD : ST_FETCH;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd_o.evict = 1'b1;
        state_nxt   = stat_i.final_ref ? ST_LOAD : ST_FETCH;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_LOAD);

endmodule

@@ hdl/opr_dp.sv @@
// Datapath of the optimal page replacement unit: reference store, frame table,
// look-ahead scan, fault counter and result register.
// Depends on opr_pkg and opr_ram.
module opr_dp #(
  parameter int REF_DEPTH   = opr_pkg::REF_DEPTH_DEF,
  parameter int FRAME_SLOTS = opr_pkg::FRAME_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  opr_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [opr_pkg::FCOUNT_W-1:0]   cfg_data,
  input  opr_pkg::opr_cmd_t              cmd_i,
  output opr_pkg::opr_stat_t             stat_o,
  output logic                           out_valid,
  output opr_pkg::out_item_t             out_data
);

  import opr_pkg::*;

  localparam int AW = $clog2(REF_DEPTH);
  localparam int CW = $clog2(REF_DEPTH + 1);
  localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  logic [FCOUNT_W-1:0] frame_count_r, frame_count_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [PAGE_W-1:0]   cur_page_r, cur_page_nxt;
  logic [PAGE_W-1:0]   frame_page_r [FRAME_SLOTS];
  logic [PAGE_W-1:0]   frame_page_nxt [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] frame_valid_r, frame_valid_nxt;
  logic [FRAME_SLOTS-1:0] found_r, found_nxt;
  logic [SW-1:0]       last_found_r, last_found_nxt;
  logic [FAULT_W-1:0]  fault_r, fault_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [PAGE_W-1:0]   rd_data;

  logic [NF_W-1:0]        fc_ext;
  logic [NF_W-1:0]        nf;
  logic [FRAME_SLOTS-1:0] act;
  logic [FRAME_SLOTS-1:0] hit_vec;
  logic [FRAME_SLOTS-1:0] free_vec;
  logic [FRAME_SLOTS-1:0] smatch;
  logic [FRAME_SLOTS-1:0] unfound;
  logic [FRAME_SLOTS-1:0] found_upd;
  logic [SW-1:0]          free_idx;
  logic [SW-1:0]          smatch_idx;
  logic [SW-1:0]          unfound_idx;
  logic                   free_got;
  logic                   smatch_got;
  logic                   unfound_got;
  logic                   all_found_now;
  logic                   all_found_reg;
  logic                   scan_more;
  logic                   is_final;
  logic [SW-1:0]          victim;
  logic [FAULT_W-1:0]     fault_inc;

  opr_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(REF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_data.page),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Active frame count, clamped to 1..FRAME_SLOTS.
  always_comb begin
    fc_ext = {1'b0, frame_count_r};
    if (fc_ext == '0) begin
      nf = NF_W'(1);
    end else if (fc_ext > NF_W'(FRAME_SLOTS)) begin
      nf = NF_W'(FRAME_SLOTS);
    end else begin
      nf = fc_ext;
    end
  end

  // All frames are compared against the read data in parallel.
  always_comb begin
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      act[j]      = NF_W'(j) < nf;
      hit_vec[j]  = frame_valid_r[j] && act[j] && (frame_page_r[j] == rd_data);
      free_vec[j] = act[j] && !frame_valid_r[j];
      smatch[j]   = rd_pend_r && act[j] && !found_r[j] && (frame_page_r[j] == rd_data);
      unfound[j]  = act[j] && !found_r[j];
    end
  end

  always_comb begin
    free_idx    = '0;
    smatch_idx  = '0;
    unfound_idx = '0;
    free_got    = 1'b0;
    smatch_got  = 1'b0;
    unfound_got = 1'b0;
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      if (free_vec[j] && !free_got) begin
        free_idx = SW'(j);
        free_got = 1'b1;
      end
      if (smatch[j] && !smatch_got) begin
        smatch_idx = SW'(j);
        smatch_got = 1'b1;
      end
      if (unfound[j] && !unfound_got) begin
        unfound_idx = SW'(j);
        unfound_got = 1'b1;
      end
    end
  end

  // Resident pages are distinct, so the frame found last in the scan is the one
  // whose next use lies farthest ahead.
  assign found_upd     = found_r | smatch;
  assign all_found_now = ((found_upd & act) == act);
  assign all_found_reg = ((found_r & act) == act);
  assign scan_more     = (k_r < count_r);
  assign is_final      = ((CW'(pos_r) + CW'(1)) == count_r);
  assign victim        = all_found_reg ? last_found_r : unfound_idx;
  assign fault_inc     = fault_r + FAULT_W'(1);

  always_comb begin
    stat_o.hit        = |hit_vec;
    stat_o.free_avail = |free_vec;
    stat_o.scan_done  = all_found_now || (!scan_more && !rd_pend_r);
    stat_o.final_ref  = is_final;
  end

  always_comb begin
    frame_count_nxt = frame_count_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    k_nxt           = k_r;
    rd_pend_nxt     = rd_pend_r;
    cur_page_nxt    = cur_page_r;
    frame_page_nxt  = frame_page_r;
    frame_valid_nxt = frame_valid_r;
    found_nxt       = found_r;
    last_found_nxt  = last_found_r;
    fault_nxt       = fault_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = pos_r;

    if (cfg_we) begin
      frame_count_nxt = cfg_data;
    end

    // References past the store depth are dropped.
    if (cmd_i.load && (count_r < CW'(REF_DEPTH))) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CW'(1);
    end

    if (cmd_i.rd_cur) begin
      rd_en = 1'b1;
    end

    if (cmd_i.cmp_take || cmd_i.evict) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.ref_index      = IDX_W'(pos_r);
      out_data_nxt.final_res      = is_final;
      out_data_nxt.evicted_valid  = 1'b0;
      out_data_nxt.evicted_page   = '0;
      out_data_nxt.slot           = '0;
      if (cmd_i.cmp_take) begin
        out_data_nxt.ref_page = rd_data;
        if (|hit_vec) begin
          out_data_nxt.hit         = 1'b1;
          out_data_nxt.fault_total = fault_r;
        end else begin
          out_data_nxt.hit          = 1'b0;
          out_data_nxt.slot         = SLOT_W'(free_idx);
          out_data_nxt.fault_total  = fault_inc;
          frame_page_nxt[free_idx]  = rd_data;
          frame_valid_nxt[free_idx] = 1'b1;
          fault_nxt                 = fault_inc;
        end
      end else begin
        out_data_nxt.ref_page      = cur_page_r;
        out_data_nxt.hit           = 1'b0;
        out_data_nxt.slot          = SLOT_W'(victim);
        out_data_nxt.evicted_valid = 1'b1;
        out_data_nxt.evicted_page  = frame_page_r[victim];
        out_data_nxt.fault_total   = fault_inc;
        frame_page_nxt[victim]     = cur_page_r;
        fault_nxt                  = fault_inc;
      end
      // The final result closes the run and frees the unit for a new string.
      if (is_final) begin
        count_nxt       = '0;
        pos_nxt         = '0;
        fault_nxt       = '0;
        frame_valid_nxt = '0;
      end else begin
        pos_nxt = pos_r + AW'(1);
      end
    end

    if (cmd_i.scan_init) begin
      cur_page_nxt = rd_data;
      k_nxt        = CW'(pos_r) + CW'(1);
      found_nxt    = '0;
      rd_pend_nxt  = 1'b0;
    end

    // Issue one read per cycle and compare the data of the previous read.
    if (cmd_i.scan_step) begin
      found_nxt = found_upd;
      if (smatch_got) begin
        last_found_nxt = smatch_idx;
      end
      rd_pend_nxt = scan_more;
      if (scan_more) begin
        rd_en   = 1'b1;
        rd_addr = k_r[AW-1:0];
        k_nxt   = k_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FCOUNT_RESET;
      count_r       <= '0;
      pos_r         <= '0;
      rd_pend_r     <= 1'b0;
      frame_valid_r <= '0;
      fault_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      frame_count_r <= frame_count_nxt;
      count_r       <= count_nxt;
      pos_r         <= pos_nxt;
      rd_pend_r     <= rd_pend_nxt;
      frame_valid_r <= frame_valid_nxt;
      fault_r       <= fault_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    cur_page_r   <= cur_page_nxt;
    frame_page_r <= frame_page_nxt;
    found_r      <= found_nxt;
    last_found_r <= last_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Resident pages stay distinct, so a lookup matches at most one frame.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.cmp_take || cmd_i.scan_init) |-> $onehot0(hit_vec))
    else $error("more than one frame holds the same page");

  // A replacement only happens with every active frame occupied.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.evict |-> ((frame_valid_r & act) == act))
    else $error("eviction while a frame is still free");

  // Faults never outnumber the references seen so far.
  a_fault_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fault_total <=
                     (FAULT_W'(out_data_r.ref_index) + FAULT_W'(1))))
    else $error("fault total exceeds reference count");

  // After the final result the run state is cleared.
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.final_res) |-> ((count_r == '0) && (fault_r == '0)
                                               && (frame_valid_r == '0)))
    else $error("run state not cleared after final result");

endmodule

@@ hdl/optimal_page_replacement_unit.sv @@
// Top level of the optimal (Belady) page replacement unit.
// Depends on opr_pkg, opr_ctrl and opr_dp (which holds the opr_ram reference store).
//
// Usage: pages of a reference string are sent one request per cycle with start
// while busy is low; each request is written to the reference store. The request
// that carries last starts the replacement simulation and raises busy until the
// final result has been given. Results come out in reference order, each on
// out_data for a single cycle marked by out_valid, and the receiver cannot stall
// them, so it must take every result in the cycle it appears. A reference that
// hits or fills a free frame passes through the fetch and compare states. A
// reference that has to evict goes through fetch, compare, scan and evict; the
// scan reads each later reference of the string in turn and stops early once
// every resident page has been seen again. The scan is paced by the single read
// port of the reference store, which delivers one stored reference per cycle to
// the parallel frame compare.
// There is no clearing pass after reset. The frame count register may be written
// whenever busy is low; cfg_ready follows that.
module optimal_page_replacement_unit #(
  parameter int REF_DEPTH   = opr_pkg::REF_DEPTH_DEF,
  parameter int FRAME_SLOTS = opr_pkg::FRAME_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  opr_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output opr_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [opr_pkg::FCOUNT_W-1:0] cfg_data
);

  import opr_pkg::*;

  opr_cmd_t  cmd;
  opr_stat_t stat;

  // Configuration is only taken while busy is low, outside the replacement simulation.
  assign cfg_ready = ~busy;

  opr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  opr_dp #(
    .REF_DEPTH   (REF_DEPTH),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
